/* design/blr_pkg.sv */
package blr_pkg;

   localparam int NUM_FEATURES = 5;
   localparam int BIN_SLOTS    = 64;
   localparam int BIN_W        = 6;
   localparam int CLASS_W      = 4;
   localparam int FEAT_W       = 32;
   localparam int PROB_W       = 16;
   localparam int PID_W        = 16;
   localparam int SEL_W        = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int NUM_EDGES    = 8;

   // energy class edges in Q16.16 GeV: 0.5, 1, 1.5, 2.5, 5, 10, 20, 50
   localparam logic [31:0] CLASS_EDGES [NUM_EDGES] = '{
      32'd32768, 32'd65536, 32'd98304, 32'd163840,
      32'd327680, 32'd655360, 32'd1310720, 32'd3276800
   };

   localparam logic ACT_LOAD     = 1'b0;
   localparam logic ACT_CLASSIFY = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPLIT          = 3'd0,
      CSR_THRESHOLD      = 3'd1,
      CSR_WIDTH_RMS      = 3'd2,
      CSR_WIDTH_START    = 3'd3,
      CSR_WIDTH_DISCREP  = 3'd4,
      CSR_WIDTH_FRACTION = 3'd5,
      CSR_WIDTH_DISTANCE = 3'd6
   } csr_index_type;

   // item control traveling down the lookup pipeline
   typedef struct packed {
      logic                valid;
      logic                classify;
      logic [CLASS_W-1:0]  cls;
      logic                err;
      logic [SEL_W-1:0]    sel;
      logic [CLASS_W-1:0]  tcls;
      logic [BIN_W-1:0]    tbin;
      logic [PROB_W-1:0]   tval;
   } ctl_type;

   // table write request to one lane
   typedef struct packed {
      logic                en;
      logic                bkg;
      logic [CLASS_W-1:0]  cls;
      logic [BIN_W-1:0]    bin;
      logic [PROB_W-1:0]   val;
   } lane_wr_type;

   // lookup request to one lane
   typedef struct packed {
      logic                en;
      logic [CLASS_W-1:0]  cls;
   } lane_rd_type;

   // classify item control in the merging pipeline
   typedef struct packed {
      logic                valid;
      logic [CLASS_W-1:0]  cls;
      logic                err;
   } meta_type;

endpackage

/* design/blr_lane.sv */
module blr_lane #(
   parameter int ENERGY_CLASSES = 9,
   parameter int BINS           = 50
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [blr_pkg::FEAT_W-1:0]    feature,
   input  logic [31:0]                   bin_width,
   input  blr_pkg::lane_rd_type          rd,
   input  blr_pkg::lane_wr_type          wr,
   output logic [blr_pkg::PROB_W-1:0]    sig_val,
   output logic [blr_pkg::PROB_W-1:0]    bkg_val
);
   import blr_pkg::*;

   localparam int DEPTH  = ENERGY_CLASSES * BIN_SLOTS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DSTG   = BIN_W + 1;

   logic [31:0]       rem_ff  [1:DSTG];
   logic [BIN_W-1:0]  quo_ff  [1:DSTG];
   logic              neg_ff  [1:DSTG];
   logic              sat_ff  [1:DSTG];
   logic [31:0]       rem_in  [2:DSTG];
   logic [BIN_W-1:0]  quo_in  [2:DSTG];
   logic [38:0]       diff;
   logic [BIN_W-1:0]  bin;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   logic [PROB_W-1:0] sig_mem [DEPTH];
   logic [PROB_W-1:0] bkg_mem [DEPTH];
   logic [PROB_W-1:0] sig_ff;
   logic [PROB_W-1:0] bkg_ff;

   // restoring division, one quotient bit per stage, top bit first
   always_comb begin
      diff = '0;
      for (int k = 2; k <= DSTG; k++) begin
         diff      = {7'b0, rem_ff[k-1]} - ({7'b0, bin_width} << (DSTG - k));
         rem_in[k] = rem_ff[k-1];
         quo_in[k] = quo_ff[k-1];
         if (!diff[38]) begin
            rem_in[k]              = diff[31:0];
            quo_in[k][DSTG - k]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[1] <= feature;
         quo_ff[1] <= '0;
         neg_ff[1] <= feature[FEAT_W-1];
         sat_ff[1] <= {6'b0, feature} >= {bin_width, 6'b0};
         for (int k = 2; k <= DSTG; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   // clamp to the table's bin count
   always_comb begin
      if (neg_ff[DSTG]) begin
         bin = '0;
      end else if (sat_ff[DSTG] || quo_ff[DSTG] > BIN_W'(BINS - 1)) begin
         bin = BIN_W'(BINS - 1);
      end else begin
         bin = quo_ff[DSTG];
      end
   end

   assign rd_addr = ADDR_W'({rd.cls, bin});
   assign wr_addr = ADDR_W'({wr.cls, wr.bin});

   // table access: loads write in pipeline order, classifies read
   always_ff @(posedge clock) begin
      if (enable && wr.en && !wr.bkg) begin
         sig_mem[wr_addr] <= wr.val;
      end
      if (enable && wr.en && wr.bkg) begin
         bkg_mem[wr_addr] <= wr.val;
      end
      if (enable && rd.en) begin
         sig_ff <= sig_mem[rd_addr];
         bkg_ff <= bkg_mem[rd_addr];
      end
   end

   assign sig_val = sig_ff;
   assign bkg_val = bkg_ff;

endmodule

/* design/blr_ratio.sv */
module blr_ratio #(
   parameter int ENERGY_CLASSES = 9
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          enable,
   input  blr_pkg::meta_type                             in_meta,
   input  logic [blr_pkg::NUM_FEATURES-1:0][blr_pkg::PROB_W-1:0] sig_vals,
   input  logic [blr_pkg::NUM_FEATURES-1:0][blr_pkg::PROB_W-1:0] bkg_vals,
   input  logic [blr_pkg::PID_W-1:0]                     threshold,
   output logic                                          out_valid,
   output logic [blr_pkg::PID_W-1:0]                     out_pid,
   output logic                                          out_accepted,
   output logic [blr_pkg::CLASS_W-1:0]                   out_class,
   output logic                                          out_error
);
   import blr_pkg::*;

   localparam int QSTG = PID_W + 1;

   meta_type     ma_ff, mb_ff, mc_ff, md_ff;
   logic [31:0]  s01_ff, s23_ff, b01_ff, b23_ff;
   logic [15:0]  s4a_ff, b4a_ff, s4b_ff, b4b_ff;
   logic [63:0]  s03_ff, b03_ff;
   logic [79:0]  sp_ff, bp_ff;
   logic [80:0]  dsig_ff, dden_ff;
   logic         dzero_ff;

   meta_type     qm_ff   [QSTG];
   logic         qz_ff   [QSTG];
   logic [80:0]  r_ff    [QSTG];
   logic [80:0]  den_ff  [QSTG];
   logic [QSTG-1:0] q_ff [QSTG];
   logic [80:0]  r_in    [QSTG];
   logic [QSTG-1:0] q_in [QSTG];
   logic [81:0]  t0;
   logic [82:0]  t1;

   logic                valid_ff;
   logic [PID_W-1:0]    pid_ff;
   logic                acc_ff;
   logic [CLASS_W-1:0]  cls_ff;
   logic                err_ff;
   logic [QSTG-1:0]     qfin;

   // combine the five lane probabilities into two exact products
   always_ff @(posedge clock) begin
      if (enable) begin
         s01_ff  <= 32'(sig_vals[0]) * 32'(sig_vals[1]);
         s23_ff  <= 32'(sig_vals[2]) * 32'(sig_vals[3]);
         b01_ff  <= 32'(bkg_vals[0]) * 32'(bkg_vals[1]);
         b23_ff  <= 32'(bkg_vals[2]) * 32'(bkg_vals[3]);
         s4a_ff  <= sig_vals[4];
         b4a_ff  <= bkg_vals[4];
         s03_ff  <= 64'(s01_ff) * 64'(s23_ff);
         b03_ff  <= 64'(b01_ff) * 64'(b23_ff);
         s4b_ff  <= s4a_ff;
         b4b_ff  <= b4a_ff;
         sp_ff   <= 80'(s03_ff) * 80'(s4b_ff);
         bp_ff   <= 80'(b03_ff) * 80'(b4b_ff);
         dsig_ff <= {1'b0, sp_ff};
         dden_ff <= {1'b0, sp_ff} + {1'b0, bp_ff};
         dzero_ff <= (sp_ff == '0) && (bp_ff == '0);
      end
   end

   // quotient bits of sig * 2^16 / (sig + bkg), one per stage
   always_comb begin
      t0 = {1'b0, dsig_ff} - {1'b0, dden_ff};
      r_in[0] = dsig_ff;
      q_in[0] = '0;
      if (!t0[81]) begin
         r_in[0]         = t0[80:0];
         q_in[0][QSTG-1] = 1'b1;
      end
      t1 = '0;
      for (int j = 1; j < QSTG; j++) begin
         t1      = {1'b0, r_ff[j-1], 1'b0} - {2'b0, den_ff[j-1]};
         r_in[j] = {r_ff[j-1][79:0], 1'b0};
         q_in[j] = q_ff[j-1];
         if (!t1[82]) begin
            r_in[j]            = t1[80:0];
            q_in[j][QSTG-1-j]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r_ff[0]   <= r_in[0];
         q_ff[0]   <= q_in[0];
         den_ff[0] <= dden_ff;
         qz_ff[0]  <= dzero_ff;
         for (int j = 1; j < QSTG; j++) begin
            r_ff[j]   <= r_in[j];
            q_ff[j]   <= q_in[j];
            den_ff[j] <= den_ff[j-1];
            qz_ff[j]  <= qz_ff[j-1];
         end
      end
   end

   // advance item control alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         ma_ff <= '0;
         mb_ff <= '0;
         mc_ff <= '0;
         md_ff <= '0;
         for (int j = 0; j < QSTG; j++) begin
            qm_ff[j] <= '0;
         end
      end else if (enable) begin
         ma_ff    <= in_meta;
         mb_ff    <= ma_ff;
         mc_ff    <= mb_ff;
         md_ff    <= mc_ff;
         qm_ff[0] <= md_ff;
         for (int j = 1; j < QSTG; j++) begin
            qm_ff[j] <= qm_ff[j-1];
         end
      end
   end

   // zero the ratio on a bad width or an empty sum
   assign qfin = (qm_ff[QSTG-1].err || qz_ff[QSTG-1]) ? '0 : q_ff[QSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= qm_ff[QSTG-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pid_ff <= qfin[QSTG-1] ? '1 : qfin[PID_W-1:0];
         acc_ff <= qfin > {1'b0, threshold};
         cls_ff <= qm_ff[QSTG-1].cls;
         err_ff <= qm_ff[QSTG-1].err;
      end
   end

   assign out_valid    = valid_ff;
   assign out_pid      = pid_ff;
   assign out_accepted = acc_ff;
   assign out_class    = cls_ff;
   assign out_error    = err_ff;

   // a width error forces an empty result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && err_ff |-> pid_ff == '0 && !acc_ff)
      else $error("width error with nonzero result");

   // the class stays inside the table range
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> cls_ff < CLASS_W'(ENERGY_CLASSES))
      else $error("energy class out of range");

   // an accepted result never falls below the threshold
   a_accept_pid: assert property (@(posedge clock) disable iff (reset)
      valid_ff && acc_ff |-> pid_ff >= threshold)
      else $error("accept flag with low ratio");

endmodule

/* design/binned_likelihood_ratio_classifier.sv */
// Binned likelihood-ratio classifier.
// Input channel (req_*): one item per transfer. action load writes one
// probability entry (table_select, table_class, table_bin, table_value) and
// gives no result; action classify bins five features, looks up a signal and
// a background probability per feature and returns one result item.
// Result channel (rsp_*): pid_value (Q0.16), accepted, energy_class and
// width_error, one transfer per classify item, in input order.
// Config channel (csr_*): always ready; write only while the block is idle.
// Throughput: one item per cycle when not held by rsp_stall; five lanes bin and
// look up in parallel. A result's path to rsp_valid is set by the 6-step bin
// division in each lane and the 17-step ratio division.
// Tables are one memory pair per lane, one access per cycle unless held; loads
// travel the same pipeline as classifies so every lookup sees earlier loads.
// Reset clears the pipeline and loads register defaults; table contents are
// undefined until loaded and no clearing pass runs.
// When rsp_stall holds a waiting result, the whole pipeline holds; the input
// register still takes one item if it is empty.
module binned_likelihood_ratio_classifier #(
   parameter int ENERGY_CLASSES   = 9,
   parameter int BINS_RMS         = 50,
   parameter int BINS_START       = 11,
   parameter int BINS_DISCREPANCY = 52,
   parameter int BINS_FRACTION    = 52,
   parameter int BINS_DISTANCE    = 50
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [31:0]                        req_cluster_energy,
   input  logic signed [31:0]                 req_peak_rms,
   input  logic signed [31:0]                 req_profile_start,
   input  logic signed [31:0]                 req_profile_discrepancy,
   input  logic signed [31:0]                 req_energy_fraction,
   input  logic signed [31:0]                 req_track_distance,
   input  logic [blr_pkg::SEL_W-1:0]          req_table_select,
   input  logic [blr_pkg::CLASS_W-1:0]        req_table_class,
   input  logic [blr_pkg::BIN_W-1:0]          req_table_bin,
   input  logic [blr_pkg::PROB_W-1:0]         req_table_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [blr_pkg::PID_W-1:0]          rsp_pid_value,
   output logic                               rsp_accepted,
   output logic [blr_pkg::CLASS_W-1:0]        rsp_energy_class,
   output logic                               rsp_width_error,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [blr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [blr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import blr_pkg::*;

   localparam int LSTG = BIN_W + 2;
   localparam int FEATURE_BINS [NUM_FEATURES] = '{
      BINS_RMS, BINS_START, BINS_DISCREPANCY, BINS_FRACTION, BINS_DISTANCE
   };

   logic                split_ff;
   logic [PID_W-1:0]    thr_ff;
   logic [31:0]         width_ff [NUM_FEATURES];

   ctl_type             ctl_ff [0:LSTG];
   ctl_type             ctl_in;
   logic [FEAT_W-1:0]   feat_ff [NUM_FEATURES];
   logic                enable;
   logic                en0;
   logic                accept;
   logic [CLASS_W-1:0]  cls_count;
   logic                width_zero;

   logic [NUM_FEATURES-1:0][PROB_W-1:0] sig_vals;
   logic [NUM_FEATURES-1:0][PROB_W-1:0] bkg_vals;
   meta_type            ratio_meta;

   // hold everything while a result waits; fill an empty input register
   assign enable    = !rsp_valid || !rsp_stall;
   assign en0       = enable || !ctl_ff[0].valid;
   assign req_stall = !en0;
   assign accept    = req_valid && en0;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff    <= 1'b1;
         thr_ff      <= 16'd32768;
         width_ff[0] <= 32'd6554;
         width_ff[1] <= 32'd65536;
         width_ff[2] <= 32'd1311;
         width_ff[3] <= 32'd1311;
         width_ff[4] <= 32'd655360;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPLIT:          split_ff    <= csr_data[0];
            CSR_THRESHOLD:      thr_ff      <= csr_data[PID_W-1:0];
            CSR_WIDTH_RMS:      width_ff[0] <= csr_data;
            CSR_WIDTH_START:    width_ff[1] <= csr_data;
            CSR_WIDTH_DISCREP:  width_ff[2] <= csr_data;
            CSR_WIDTH_FRACTION: width_ff[3] <= csr_data;
            CSR_WIDTH_DISTANCE: width_ff[4] <= csr_data;
            default: ;
         endcase
      end
   end

   // energy class from the edges (zero when split is off), and the zero-width flag
   always_comb begin
      cls_count  = '0;
      width_zero = 1'b0;
      for (int i = 0; i < NUM_EDGES; i++) begin
         if (req_cluster_energy > CLASS_EDGES[i]) begin
            cls_count = CLASS_W'(i + 1);
         end
      end
      if (!split_ff) begin
         cls_count = '0;
      end
      if (cls_count > CLASS_W'(ENERGY_CLASSES - 1)) begin
         cls_count = CLASS_W'(ENERGY_CLASSES - 1);
      end
      for (int i = 0; i < NUM_FEATURES; i++) begin
         if (width_ff[i] == '0) begin
            width_zero = 1'b1;
         end
      end
      ctl_in.valid    = accept;
      ctl_in.classify = req_action == ACT_CLASSIFY;
      ctl_in.cls      = cls_count;
      ctl_in.err      = width_zero;
      ctl_in.sel      = req_table_select;
      ctl_in.tcls     = req_table_class;
      ctl_in.tbin     = req_table_bin;
      ctl_in.tval     = req_table_value;
   end

   // input register
   always_ff @(posedge clock) begin
      if (en0) begin
         feat_ff[0] <= req_peak_rms;
         feat_ff[1] <= req_profile_start;
         feat_ff[2] <= req_profile_discrepancy;
         feat_ff[3] <= req_energy_fraction;
         feat_ff[4] <= req_track_distance;
      end
   end

   // advance item control through the lookup stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LSTG; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         if (en0) begin
            ctl_ff[0] <= ctl_in;
         end
         if (enable) begin
            for (int k = 1; k <= LSTG; k++) begin
               ctl_ff[k] <= ctl_ff[k-1];
            end
         end
      end
   end

   // one lane per feature
   for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_lane
      lane_rd_type rd;
      lane_wr_type wr;

      assign rd.en  = ctl_ff[LSTG-1].valid && ctl_ff[LSTG-1].classify;
      assign rd.cls = ctl_ff[LSTG-1].cls;
      assign wr.en  = ctl_ff[LSTG-1].valid && !ctl_ff[LSTG-1].classify
                      && ctl_ff[LSTG-1].sel[SEL_W-1:1] == (SEL_W-1)'(g)
                      && ctl_ff[LSTG-1].tcls < CLASS_W'(ENERGY_CLASSES);
      assign wr.bkg = ctl_ff[LSTG-1].sel[0];
      assign wr.cls = ctl_ff[LSTG-1].tcls;
      assign wr.bin = ctl_ff[LSTG-1].tbin;
      assign wr.val = ctl_ff[LSTG-1].tval;

      blr_lane #(
         .ENERGY_CLASSES (ENERGY_CLASSES),
         .BINS           (FEATURE_BINS[g])
      ) u_lane (
         .clock     (clock),
         .enable    (enable),
         .feature   (feat_ff[g]),
         .bin_width (width_ff[g]),
         .rd        (rd),
         .wr        (wr),
         .sig_val   (sig_vals[g]),
         .bkg_val   (bkg_vals[g])
      );
   end

   assign ratio_meta.valid = ctl_ff[LSTG].valid && ctl_ff[LSTG].classify;
   assign ratio_meta.cls   = ctl_ff[LSTG].cls;
   assign ratio_meta.err   = ctl_ff[LSTG].err;

   // merge lanes and form the ratio
   blr_ratio #(
      .ENERGY_CLASSES (ENERGY_CLASSES)
   ) u_ratio (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_meta      (ratio_meta),
      .sig_vals     (sig_vals),
      .bkg_vals     (bkg_vals),
      .threshold    (thr_ff),
      .out_valid    (rsp_valid),
      .out_pid      (rsp_pid_value),
      .out_accepted (rsp_accepted),
      .out_class    (rsp_energy_class),
      .out_error    (rsp_width_error)
   );

   // input is refused only while the pipeline holds a full input register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && ctl_ff[0].valid)
      else $error("input refused without a held result");

   // a held result freezes the input register contents
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(ctl_ff[0]))
      else $error("input register moved while held");

   // load items never reach the merging pipeline
   a_load_dropped: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[LSTG].valid && !ctl_ff[LSTG].classify |-> !ratio_meta.valid)
      else $error("load item entered the ratio pipeline");

endmodule
